/* rtl/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// shared types and constants for the pressure compensation pipeline
// ----------------------------------------------------------------------------
package psc_pkg;

   localparam int RawWidth  = 20;
   localparam int TempWidth = 32;
   localparam int CoefWidth = 16;
   localparam int WordWidth = 64;
   localparam int QuoBits   = 64;

   // register indexes
   localparam logic [2:0] RegP1   = 3'd0;
   localparam logic [2:0] RegP2   = 3'd1;
   localparam logic [2:0] RegP3   = 3'd2;
   localparam logic [2:0] RegP4   = 3'd3;
   localparam logic [2:0] RegP5   = 3'd4;
   localparam logic [2:0] RegP6   = 3'd5;
   localparam logic [2:0] RegP7   = 3'd6;
   localparam logic [2:0] RegP8P9 = 3'd7;

   localparam logic [63:0] TempOffset = 64'd128000;
   localparam logic [63:0] OneQ47     = 64'd1 << 47;
   localparam logic [63:0] FullScale  = 64'd1048576;
   localparam logic [63:0] ScaleK     = 64'd3125;

   typedef struct packed {
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } coef_type;

   // item travelling from front end into the divider
   typedef struct packed {
      logic [63:0] num;   // dividend
      logic [63:0] den;   // divisor
   } div_req_type;

   // item leaving the divider
   typedef struct packed {
      logic [63:0] quo;
      logic        dz;
   } div_rsp_type;

   function automatic logic [63:0] sext16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

endpackage

/* rtl/psc_front.sv */
// ----------------------------------------------------------------------------
// psc_front
// pipelined dividend and divisor computation from raw reading and t_fine
// ----------------------------------------------------------------------------
module psc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     stall,
   input  psc_pkg::coef_type        coef,
   input  logic                     in_valid,
   input  logic [19:0]              raw_pressure,
   input  logic [31:0]              temp_fine,
   output logic                     out_valid,
   output psc_pkg::div_req_type     out_data
);

   localparam int Stages = 5;

   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] vld_in;

   // stage 1: a, raw term
   logic [63:0] s1_a_ff, s1_a_in;
   logic [63:0] s1_p_ff, s1_p_in;
   // stage 2: a*a, a*p5, a*p2
   logic [63:0] s2_aa_ff, s2_ap5_ff, s2_ap2_ff, s2_p_ff;
   // stage 3: a*a*p6, a*a*p3
   logic [63:0] s3_b_ff, s3_a_ff, s3_p_ff;
   // stage 4: (1<<47 + a)*p1, dividend base
   logic [63:0] s4_den_ff, s4_num_ff;
   // stage 5: *3125
   logic [63:0] s5_den_ff, s5_num_ff;

   logic [65:0] aa_wide;
   logic [63:0] aa_full, ap5, ap2, b_sum, a_sum, den_full, num_base, num_full;

   assign vld_in = {vld_ff[Stages-2:0], in_valid};

   always_comb begin
      s1_a_in  = {{32{temp_fine[31]}}, temp_fine} - psc_pkg::TempOffset;
      s1_p_in  = (psc_pkg::FullScale - {44'd0, raw_pressure}) << 31;
      // a always fits in 33 signed bits
      aa_wide  = $signed(s1_a_ff[32:0]) * $signed(s1_a_ff[32:0]);
      aa_full  = aa_wide[63:0];
      ap5      = s1_a_ff * psc_pkg::sext16(coef.p5);
      ap2      = s1_a_ff * psc_pkg::sext16(coef.p2);
      b_sum    = s2_aa_ff * psc_pkg::sext16(coef.p6) + (s2_ap5_ff << 17)
                 + (psc_pkg::sext16(coef.p4) << 35);
      a_sum    = $signed($signed(s2_aa_ff * psc_pkg::sext16(coef.p3)) >>> 8)
                 + (s2_ap2_ff << 12);
      den_full = $signed($signed((psc_pkg::OneQ47 + s3_a_ff)
                 * {48'd0, coef.p1}) >>> 33);
      num_base = s3_p_ff - s3_b_ff;
      num_full = s4_num_ff * psc_pkg::ScaleK;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (!stall) begin
         vld_ff <= vld_in;
      end
   end

   // data stages
   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_a_ff   <= s1_a_in;
         s1_p_ff   <= s1_p_in;
         s2_aa_ff  <= aa_full;
         s2_ap5_ff <= ap5;
         s2_ap2_ff <= ap2;
         s2_p_ff   <= s1_p_ff;
         s3_b_ff   <= b_sum;
         s3_a_ff   <= a_sum;
         s3_p_ff   <= s2_p_ff;
         s4_den_ff <= den_full;
         s4_num_ff <= num_base;
         s5_den_ff <= s4_den_ff;
         s5_num_ff <= num_full;
      end
   end

   assign out_valid    = vld_ff[Stages-1];
   assign out_data.num = s5_num_ff;
   assign out_data.den = s5_den_ff;

endmodule

/* rtl/psc_div.sv */
// ----------------------------------------------------------------------------
// psc_div
// pipelined signed 64-bit divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module psc_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     stall,
   input  logic                     in_valid,
   input  psc_pkg::div_req_type     in_data,
   output logic                     out_valid,
   output psc_pkg::div_rsp_type     out_data
);

   localparam int N = psc_pkg::QuoBits;

   // stage 0 takes magnitudes, stages 1..N do one bit each
   logic [N:0]    vld_ff;
   logic [63:0]   rem_ff [N+1];
   logic [63:0]   quo_ff [N+1];
   logic [63:0]   dvs_ff [N+1];
   logic          neg_ff [N+1];
   logic          dz_ff  [N+1];

   logic [63:0]   mag_a, mag_b;

   assign mag_a = in_data.num[63] ? -in_data.num : in_data.num;
   assign mag_b = in_data.den[63] ? -in_data.den : in_data.den;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (!stall) begin
         vld_ff <= {vld_ff[N-1:0], in_valid};
      end
   end

   // entry stage
   always_ff @(posedge clock) begin
      if (!stall) begin
         rem_ff[0] <= '0;
         quo_ff[0] <= mag_a;
         dvs_ff[0] <= mag_b;
         neg_ff[0] <= in_data.num[63] ^ in_data.den[63];
         dz_ff[0]  <= (in_data.den == '0);
      end
   end

   // restoring steps, dividend shifts out of quo as quotient shifts in
   for (genvar k = 1; k <= N; k++) begin : g_step
      logic [64:0] trial;
      logic [64:0] shifted;
      assign shifted = {rem_ff[k-1], quo_ff[k-1][63]};
      assign trial   = shifted - {1'b0, dvs_ff[k-1]};
      always_ff @(posedge clock) begin
         if (!stall) begin
            if (!trial[64]) begin
               rem_ff[k] <= trial[63:0];
               quo_ff[k] <= {quo_ff[k-1][62:0], 1'b1};
            end else begin
               rem_ff[k] <= shifted[63:0];
               quo_ff[k] <= {quo_ff[k-1][62:0], 1'b0};
            end
            dvs_ff[k] <= dvs_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            dz_ff[k]  <= dz_ff[k-1];
         end
      end
   end

   assign out_valid    = vld_ff[N];
   assign out_data.quo = neg_ff[N] ? -quo_ff[N] : quo_ff[N];
   assign out_data.dz  = dz_ff[N];

endmodule

/* rtl/psc_back.sv */
// ----------------------------------------------------------------------------
// psc_back
// nonlinear correction, offset and saturation after the division
// ----------------------------------------------------------------------------
module psc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     stall,
   input  psc_pkg::coef_type        coef,
   input  logic                     in_valid,
   input  psc_pkg::div_rsp_type     in_data,
   output logic                     out_valid,
   output logic [31:0]              pressure_q24_8,
   output logic                     divide_by_zero
);

   localparam int Stages = 5;

   logic [Stages-1:0] vld_ff;
   logic [63:0] s1_p_ff, s1_h_ff, s1_p9h_ff;
   logic        s1_dz_ff;
   logic [63:0] s2_p_ff, s2_ll_ff, s2_b_ff;
   logic [31:0] s2_mid_ff;
   logic        s2_dz_ff;
   logic [63:0] s3_p_ff, s3_a_ff, s3_b_ff;
   logic        s3_dz_ff;
   logic [63:0] s4_p_ff;
   logic        s4_dz_ff;
   logic [31:0] s5_res_ff;
   logic        s5_dz_ff;

   logic [63:0] h, p9h, pp_ll, a_full, b_full, p_sum, sat_in;
   logic [31:0] pp_lh, pp_hl, mid;
   logic [31:0] sat_out;

   always_comb begin
      h      = $signed(in_data.quo) >>> 13;
      p9h    = psc_pkg::sext16(coef.p9) * h;
      // low 64 bits of p9h * h from 32-bit partial products
      pp_ll  = s1_p9h_ff[31:0] * s1_h_ff[31:0];
      pp_lh  = s1_p9h_ff[31:0] * s1_h_ff[63:32];
      pp_hl  = s1_p9h_ff[63:32] * s1_h_ff[31:0];
      mid    = pp_lh + pp_hl;
      b_full = $signed(psc_pkg::sext16(coef.p8) * s1_p_ff) >>> 19;
      a_full = $signed(s2_ll_ff + {s2_mid_ff, 32'd0}) >>> 25;
      p_sum  = $signed($signed(s3_p_ff + s3_a_ff + s3_b_ff) >>> 8)
               + (psc_pkg::sext16(coef.p7) << 4);
      sat_in = s4_p_ff;
      if (sat_in[63] && !(&sat_in[62:31])) begin
         sat_out = 32'h8000_0000;
      end else if (!sat_in[63] && (|sat_in[62:31])) begin
         sat_out = 32'h7FFF_FFFF;
      end else begin
         sat_out = sat_in[31:0];
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (!stall) begin
         vld_ff <= {vld_ff[Stages-2:0], in_valid};
      end
   end

   // data stages
   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_p_ff   <= in_data.quo;
         s1_h_ff   <= h;
         s1_p9h_ff <= p9h;
         s1_dz_ff  <= in_data.dz;
         s2_p_ff   <= s1_p_ff;
         s2_ll_ff  <= pp_ll;
         s2_mid_ff <= mid;
         s2_b_ff   <= b_full;
         s2_dz_ff  <= s1_dz_ff;
         s3_p_ff   <= s2_p_ff;
         s3_a_ff   <= a_full;
         s3_b_ff   <= s2_b_ff;
         s3_dz_ff  <= s2_dz_ff;
         s4_p_ff   <= p_sum;
         s4_dz_ff  <= s3_dz_ff;
         s5_res_ff <= s4_dz_ff ? 32'd0 : sat_out;
         s5_dz_ff  <= s4_dz_ff;
      end
   end

   assign out_valid      = vld_ff[Stages-1];
   assign pressure_q24_8 = s5_res_ff;
   assign divide_by_zero = s5_dz_ff;

endmodule

/* rtl/pressure_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// 64-bit integer barometric pressure compensation, Q24.8 output
// ----------------------------------------------------------------------------
// Takes one beat per cycle while not stalled and returns one result beat per
// input beat, in order. The path runs through 5 front-end stages for the divisor and
// dividend, 65 stages of the bit-per-stage 64-bit divider, 5 stages of
// correction and saturation, and an output register. The whole pipeline
// freezes while the output register holds an untaken beat.
module pressure_sensor_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // raw_pressure[19:0], temp_fine[51:20], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pressure_q24_8[31:0]
   output logic        rsp_tuser    // divide_by_zero
);

   psc_pkg::coef_type     coef_ff;
   psc_pkg::div_req_type  fe_data;
   psc_pkg::div_rsp_type  dv_data;
   logic                  fe_valid, dv_valid, be_valid;
   logic [31:0]           be_pres;
   logic                  be_dz;
   logic                  stall;
   logic                  out_vld_ff;
   logic [31:0]           out_pres_ff;
   logic                  out_dz_ff;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            psc_pkg::RegP1:   coef_ff.p1 <= csr_wdata[15:0];
            psc_pkg::RegP2:   coef_ff.p2 <= csr_wdata[15:0];
            psc_pkg::RegP3:   coef_ff.p3 <= csr_wdata[15:0];
            psc_pkg::RegP4:   coef_ff.p4 <= csr_wdata[15:0];
            psc_pkg::RegP5:   coef_ff.p5 <= csr_wdata[15:0];
            psc_pkg::RegP6:   coef_ff.p6 <= csr_wdata[15:0];
            psc_pkg::RegP7:   coef_ff.p7 <= csr_wdata[15:0];
            psc_pkg::RegP8P9: begin
               coef_ff.p8 <= csr_wdata[15:0];
               coef_ff.p9 <= csr_wdata[31:16];
            end
            default: ;
         endcase
      end
   end

   // stall whole pipe when output holds an untaken beat
   assign stall      = out_vld_ff && !rsp_tready;
   assign req_tready = !stall;

   psc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .stall        (stall),
      .coef         (coef_ff),
      .in_valid     (req_tvalid),
      .raw_pressure (req_tdata[19:0]),
      .temp_fine    (req_tdata[51:20]),
      .out_valid    (fe_valid),
      .out_data     (fe_data)
   );

   psc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .stall     (stall),
      .in_valid  (fe_valid),
      .in_data   (fe_data),
      .out_valid (dv_valid),
      .out_data  (dv_data)
   );

   psc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .stall          (stall),
      .coef           (coef_ff),
      .in_valid       (dv_valid),
      .in_data        (dv_data),
      .out_valid      (be_valid),
      .pressure_q24_8 (be_pres),
      .divide_by_zero (be_dz)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (!stall) begin
         out_vld_ff <= be_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         out_pres_ff <= be_pres;
         out_dz_ff   <= be_dz;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_pres_ff;
   assign rsp_tuser  = out_dz_ff;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the pressure compensation pipeline against its own integer predictor
// ----------------------------------------------------------------------------
// Coefficients are written while the pipeline is empty. A directed set of beats
// covers the field extremes and the zero divisor, then random beats are sent
// with random gaps on both sides and one long receiver hold-off. Every result
// beat is compared in order with the predicted pressure and flag.
module tb;

   localparam int Latency   = 76;
   localparam int CycleCap  = 400000;

   typedef struct {
      logic [31:0] pressure;
      logic        dz;
   } pressure_result_type;

   // in-order store of predicted results and the coefficients they use
   class pressure_scoreboard;
      logic [15:0]         coef[8];
      logic [31:0]         coef_p8_p9;
      pressure_result_type pending[$];
      int                  fails;
      int                  checked;
      int                  dz_seen;

      function automatic logic [63:0] asr(input logic [63:0] x, input int n);
         return $signed(x) >>> n;
      endfunction

      function automatic logic [63:0] sdiv(input logic [63:0] a, input logic [63:0] b);
         logic [63:0] ma, mb, q;
         ma = a[63] ? -a : a;
         mb = b[63] ? -b : b;
         q  = ma / mb;
         return (a[63] != b[63]) ? -q : q;
      endfunction

      function automatic void note_input(input logic [19:0] raw, input logic [31:0] tfine);
         logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, h;
         pressure_result_type r;
         p1 = {48'd0, coef[psc_pkg::RegP1]};
         p2 = psc_pkg::sext16(coef[psc_pkg::RegP2]);
         p3 = psc_pkg::sext16(coef[psc_pkg::RegP3]);
         p4 = psc_pkg::sext16(coef[psc_pkg::RegP4]);
         p5 = psc_pkg::sext16(coef[psc_pkg::RegP5]);
         p6 = psc_pkg::sext16(coef[psc_pkg::RegP6]);
         p7 = psc_pkg::sext16(coef[psc_pkg::RegP7]);
         p8 = psc_pkg::sext16(coef_p8_p9[15:0]);
         p9 = psc_pkg::sext16(coef_p8_p9[31:16]);
         a = {{32{tfine[31]}}, tfine} - 64'd128000;
         b = a * a * p6;
         b = b + ((a * p5) << 17);
         b = b + (p4 << 35);
         a = asr(a * a * p3, 8) + ((a * p2) << 12);
         a = asr(((64'd1 << 47) + a) * p1, 33);
         if (a == 0) begin
            r.pressure = 0;
            r.dz = 1;
         end else begin
            p = 64'd1048576 - {44'd0, raw};
            p = sdiv(((p << 31) - b) * 64'd3125, a);
            h = asr(p, 13);
            a = asr(p9 * h * h, 25);
            b = asr(p8 * p, 19);
            p = asr(p + a + b, 8) + (p7 << 4);
            if ($signed(p) < -64'sd2147483648) p = 64'h8000_0000;
            else if ($signed(p) > 64'sd2147483647) p = 64'h7FFF_FFFF;
            r.pressure = p[31:0];
            r.dz = 0;
         end
         pending.push_back(r);
      endfunction

      function automatic void check_result(input logic [31:0] pressure, input logic dz);
         pressure_result_type e;
         if (pending.size() == 0) begin
            $error("result beat with nothing expected: pressure %h", pressure);
            fails++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (dz) dz_seen++;
         if (pressure !== e.pressure) begin
            $error("pressure_q24_8 expected %h actual %h", e.pressure, pressure);
            fails++;
         end
         if (dz !== e.dz) begin
            $error("divide_by_zero expected %b actual %b", e.dz, dz);
            fails++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_index = psc_pkg::RegP1;
   logic [31:0] csr_wdata = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = 0;   // raw_pressure[19:0], temp_fine[51:20], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;      // pressure_q24_8[31:0]
   logic        rsp_tuser;      // divide_by_zero

   pressure_scoreboard board = new();
   bit  hold_off_on = 0;
   bit  hold_off_done = 0;
   int  cycles = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   pressure_sensor_compensation DUT (.*);

   // cycle cap
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleCap) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tuser);
      if (reset || hold_off_on)
         rsp_tready <= 0;
      else if ($urandom_range(0, 9) < 7)
         rsp_tready <= 1;
      else
         rsp_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
   end

   initial begin
      int n;
      wait (hold_off_on);
      n = 0;
      while (n < 300) begin
         @(posedge clock);
         n++;
      end
      hold_off_on = 0;
      hold_off_done = 1;
   end

   task automatic write_coef(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == psc_pkg::RegP8P9) board.coef_p8_p9 = val;
      else board.coef[idx] = val[15:0];
      @(posedge clock);
      csr_we <= 0;
   endtask

   // entered at a clock edge; returns at the edge that accepts the beat
   task automatic send_sample(input logic [19:0] raw, input logic [31:0] tfine);
      int gap;
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
      if ($urandom_range(0, 3) == 0) gap = 0;
      // idle cycles before this beat
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'd0, tfine, raw};
      do @(posedge clock); while (!req_tready);
      board.note_input(raw, tfine);
   endtask

   task automatic drain;
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
   endtask

   // realistic coefficient set with some spread
   task automatic typical_coefs;
      write_coef(psc_pkg::RegP1, 36000 + $urandom_range(0, 4000));
      write_coef(psc_pkg::RegP2, -10700 + $urandom_range(0, 200) - 100);
      write_coef(psc_pkg::RegP3, 3024);
      write_coef(psc_pkg::RegP4, 2855 + $urandom_range(0, 4000));
      write_coef(psc_pkg::RegP5, 140);
      write_coef(psc_pkg::RegP6, -7);
      write_coef(psc_pkg::RegP7, 15500);
      write_coef(psc_pkg::RegP8P9, {16'd6000, 16'hC1F0});
   endtask

   task automatic random_coefs;
      for (int i = 0; i < 8; i++)
         write_coef(i[2:0], $urandom());
   endtask

   initial begin
      logic [31:0] tf;
      repeat (4) @(posedge clock);
      reset <= 0;

      // all zero: every divisor is zero
      send_sample(20'd0, 32'd0);
      send_sample(20'hFFFFF, 32'h7FFF_FFFF);
      drain();

      // extremes of every coefficient
      for (int i = 0; i < 7; i++) write_coef(i[2:0], 32'h0000_8000);
      write_coef(psc_pkg::RegP1, 32'hFFFF);
      write_coef(psc_pkg::RegP8P9, 32'h8000_8000);
      send_sample(20'd0, 32'h8000_0000);
      send_sample(20'hFFFFF, 32'h7FFF_FFFF);
      send_sample(20'h80000, 32'd128000);
      drain();
      for (int i = 0; i < 7; i++) write_coef(i[2:0], 32'hFFFF_7FFF);
      write_coef(psc_pkg::RegP1, 32'd1);
      write_coef(psc_pkg::RegP8P9, 32'h7FFF_7FFF);
      send_sample(20'd0, 32'h8000_0000);
      send_sample(20'hFFFFF, 32'h7FFF_FFFF);
      send_sample(20'h12345, 32'd128000);
      drain();

      // typical sensor values, field extremes, clamping both ways
      typical_coefs();
      send_sample(20'd415148, 32'd128422);
      send_sample(20'd0, 32'd100000);
      send_sample(20'hFFFFF, 32'd150000);
      send_sample(20'h55555, 32'hAAAA_AAAA);
      send_sample(20'hAAAAA, 32'h5555_5555);
      send_sample(20'd1, 32'hFFFF_FFFF);
      drain();

      // random phases: typical and fully random coefficients, random samples
      for (int ph = 0; ph < 6; ph++) begin
         if (ph % 2 == 0) typical_coefs(); else random_coefs();
         if (ph == 2) hold_off_on = 1;
         for (int k = 0; k < 75; k++) begin
            if ($urandom_range(0, 3) != 0)
               tf = $urandom_range(60000, 200000);
            else
               tf = $urandom();
            send_sample(20'($urandom_range(0, 20'hFFFFF)), tf);
         end
         drain();
      end
      wait (hold_off_done);
      drain();

      $display("checked %0d result beats, %0d with a zero divisor", board.checked,
               board.dz_seen);
      if (board.fails == 0 && board.pending.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

/* files.f */
rtl/psc_pkg.sv
rtl/psc_front.sv
rtl/psc_div.sv
rtl/psc_back.sv
rtl/pressure_sensor_compensation.sv
verif/tb.sv
